/* src/pmas_pkg.sv */
// Shared constants and helpers for the potentiometer moving-average scaler.
package pmas_pkg;

  localparam int WINDOW_DEF  = 8;
  localparam int SAMPLE_W    = 12;
  localparam int OUT_W       = 16;
  localparam int PROD_W      = SAMPLE_W + OUT_W;
  localparam int BITS_W      = 5;
  localparam int BITS_MAX    = 16;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BITS_W-1:0]   BITS_RESET = 5'd12;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;

  // register index, taken from paddr[2]
  localparam logic REG_OUTPUT_BITS = 1'b0;

  // (2^bits - 1), with bits saturated at sixteen
  function automatic logic [OUT_W-1:0] scale_factor(input logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] b;
    logic [OUT_W:0]    t;
    b = (bits > BITS_W'(BITS_MAX)) ? BITS_W'(BITS_MAX) : bits;
    t = ((OUT_W + 1)'(1) << b) - (OUT_W + 1)'(1);
    return t[OUT_W-1:0];
  endfunction

endpackage

/* src/pot_moving_average_scaler.sv */
// Top level of the potentiometer moving-average scaler.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[11:0] sample
//  m_axis    out  m_axis_tvalid/tready        tdata[15:0] scaled_value, tuser value_changed
//  apb       in   psel/penable/pwrite/pready  reg 0 @ 0x0: output_bits[4:0], reset 12
//
//  Front end reads the ring when it takes a sample, then writes it and updates the sum;
//  it takes no new sample in between. The back end sets the rate: a load, the divide
//  steps, a multiply, the reduce steps and the output, one entry at a time.
//  A two-entry queue lets the front run ahead while the output is stalled.
//  Reset is asynchronous; no clearing pass, ring entries are used only once written.
module pot_moving_average_scaler #(
  parameter int WINDOW = pmas_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pmas_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] sample, [15:12] zero
  // stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pmas_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] scaled_value
  output logic                             m_axis_tuser,   // [0] value_changed
  // config
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pmas_pkg::ADDR_W-1:0]      paddr,
  input  logic [pmas_pkg::DATA_W-1:0]      pwdata,
  output logic [pmas_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = pmas_pkg::SAMPLE_W + CNT_W;
  localparam int ENTRY_W = SUM_W + CNT_W;

  logic [pmas_pkg::BITS_W-1:0] bits_q, bits_d;
  logic                        cfg_wr;

  logic                        q_push, q_pop, q_full, q_valid;
  logic [SUM_W-1:0]            f_sum;
  logic [CNT_W-1:0]            f_cnt;
  logic [ENTRY_W-1:0]          q_out;
  logic [pmas_pkg::OUT_W-1:0]  b_value;

  // config register, written on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pmas_pkg::REG_OUTPUT_BITS);
  assign bits_d = cfg_wr ? pwdata[pmas_pkg::BITS_W-1:0] : bits_q;
  assign prdata = (paddr[2] == pmas_pkg::REG_OUTPUT_BITS) ?
                  pmas_pkg::DATA_W'(bits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= pmas_pkg::BITS_RESET;
    end else begin
      bits_q <= bits_d;
    end
  end

  pmas_front #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_sample_i (s_axis_tdata[pmas_pkg::SAMPLE_W-1:0]),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_sum_o    (f_sum),
    .q_cnt_o    (f_cnt)
  );

  // each entry: {count, window sum}
  pmas_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (pmas_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_cnt, f_sum}),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  pmas_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_sum_i     (q_out[SUM_W-1:0]),
    .q_cnt_i     (q_out[ENTRY_W-1:SUM_W]),
    .q_pop_o     (q_pop),
    .out_bits_i  (bits_q),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_value_o   (b_value),
    .m_changed_o (m_axis_tuser)
  );

  assign m_axis_tdata = pmas_pkg::OUT_TDATA_W'(b_value);

endmodule

/* src/pmas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pmas_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pmas_front.sv */
// Front end: takes samples, keeps the sample ring and running window sum.
module pmas_front #(
  parameter int WINDOW = 8,
  parameter int SLOT_W = 3,
  parameter int CNT_W  = 4,
  parameter int SUM_W  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [pmas_pkg::SAMPLE_W-1:0] s_sample_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic [SUM_W-1:0]              q_sum_o,
  output logic [CNT_W-1:0]              q_cnt_o
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_UPD  = 1'b1;

  logic                          state_q, state_d;
  logic [SLOT_W-1:0]             slot_q, slot_d, slot_nx;
  logic                          full_q, full_d, full_nx;
  logic [SUM_W-1:0]              sum_q, sum_d, sum_upd;
  logic [pmas_pkg::SAMPLE_W-1:0] sample_q;
  logic [pmas_pkg::SAMPLE_W-1:0] ring_rdata;
  logic [pmas_pkg::SAMPLE_W-1:0] old_sample;
  logic                          accept;
  logic                          last_slot;

  assign s_ready_o = (state_q == F_IDLE) && !q_full_i;
  assign accept    = s_valid_i && s_ready_o;

  // old entry is read at accept and arrives the cycle after
  pmas_ram #(
    .WIDTH (pmas_pkg::SAMPLE_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == F_UPD),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (accept),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    last_slot  = (slot_q == SLOT_W'(WINDOW - 1));
    slot_nx    = last_slot ? '0 : slot_q + 1'b1;
    full_nx    = full_q | last_slot;
    // before the first wrap the slot being written was never filled
    old_sample = full_q ? ring_rdata : '0;
    sum_upd    = sum_q + SUM_W'(sample_q) - SUM_W'(old_sample);
  end

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    full_d   = full_q;
    sum_d    = sum_q;
    q_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_UPD;
        end
      end
      F_UPD: begin
        q_push_o = 1'b1;
        slot_d   = slot_nx;
        full_d   = full_nx;
        sum_d    = sum_upd;
        state_d  = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign q_sum_o = sum_upd;
  assign q_cnt_o = full_nx ? CNT_W'(WINDOW) : CNT_W'(slot_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      slot_q  <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      full_q  <= full_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_sample_i;
    end
  end

endmodule

/* src/pmas_queue.sv */
// Short FIFO between front and back ends.
module pmas_queue #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  // DEPTH is a power of two, pointers wrap on their own
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

/* src/pmas_back.sv */
// Back end: mean by iterative division, scaling, divide by full scale, change flag.
module pmas_back #(
  parameter int CNT_W = 4,
  parameter int SUM_W = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  logic [SUM_W-1:0]            q_sum_i,
  input  logic [CNT_W-1:0]            q_cnt_i,
  output logic                        q_pop_o,
  input  logic [pmas_pkg::BITS_W-1:0] out_bits_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [pmas_pkg::OUT_W-1:0]  m_value_o,
  output logic                        m_changed_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int SW     = pmas_pkg::SAMPLE_W;
  localparam int PW     = pmas_pkg::PROD_W;
  localparam int OW     = pmas_pkg::OUT_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_RED  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PW-1:0]     r_q, r_d;
  logic [OW-1:0]     acc_q, acc_d;
  logic [OW-1:0]     prev_q, prev_d;
  logic              out_valid_q, out_valid_d;
  logic [OW-1:0]     out_value_q, out_value_d;
  logic              out_chg_q, out_chg_d;

  logic [CNT_W:0]    rem_sh, rem_diff;
  logic              ge;
  logic [PW-1:0]     prod;
  logic [OW-1:0]     r_hi;
  logic [SW-1:0]     r_lo;
  logic              out_free;

  // one restoring division step, quotient bits shift into the dividend
  always_comb begin
    rem_sh   = {rem_q, dvd_q[SUM_W-1]};
    ge       = (rem_sh >= {1'b0, div_q});
    rem_diff = rem_sh - {1'b0, div_q};
  end

  assign prod     = dvd_q[SW-1:0] * pmas_pkg::scale_factor(out_bits_i);
  assign r_hi     = r_q[PW-1:SW];
  assign r_lo     = r_q[SW-1:0];
  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    r_d         = r_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_value_d = out_value_q;
    out_chg_d   = out_chg_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          dvd_d   = q_sum_i;
          div_d   = q_cnt_i;
          rem_d   = '0;
          step_d  = STEP_W'(SUM_W);
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        dvd_d  = {dvd_q[SUM_W-2:0], ge};
        rem_d  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        step_d = step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        r_d     = prod;
        acc_d   = '0;
        state_d = B_RED;
      end
      B_RED: begin
        // x / 4095: fold the 4096s back in, since 4096 = 4095 + 1
        if (r_hi != '0) begin
          acc_d = acc_q + r_hi;
          r_d   = PW'(r_lo) + PW'(r_hi);
        end else if (r_lo == pmas_pkg::FULL_SCALE) begin
          acc_d = acc_q + 1'b1;
          r_d   = '0;
        end else begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = acc_q;
          out_chg_d   = (acc_q != prev_q);
          prev_d      = acc_q;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    r_q         <= r_d;
    acc_q       <= acc_d;
    out_value_q <= out_value_d;
    out_chg_q   <= out_chg_d;
  end

  assign m_valid_o   = out_valid_q;
  assign m_value_o   = out_value_q;
  assign m_changed_o = out_chg_q;

endmodule

/* src/pmas_checker.sv */
// Port-level checks for the moving-average scaler, bound to the top level.
module pmas_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pmas_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pmas_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [pmas_pkg::ADDR_W-1:0]      paddr,
  input logic [pmas_pkg::DATA_W-1:0]      pwdata,
  input logic [pmas_pkg::DATA_W-1:0]      prdata,
  input logic                             pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // front end handles one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one still updating");

  // no valid result once reset has been sampled low
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // register readback follows a write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == pmas_pkg::REG_OUTPUT_BITS) |=>
      (paddr[2] != pmas_pkg::REG_OUTPUT_BITS) ||
      (prdata[pmas_pkg::BITS_W-1:0] == $past(pwdata[pmas_pkg::BITS_W-1:0])))
    else $error("output_bits readback mismatch");

endmodule

bind pot_moving_average_scaler pmas_checker u_pmas_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the potentiometer moving-average scaler.
module testbench;
  import pmas_pkg::*;

  localparam int WIN         = WINDOW_DEF;
  localparam int TAIL_CYCLES = 40;      // longer than one pass through the back end
  localparam int LIMIT       = 500000;  // far above the slowest legal run
  localparam int PHASE_ITEMS = 105;

  // register addresses: index from paddr[2]; index one has no register behind it
  localparam logic               REG_NONE  = 1'b1;
  localparam logic [ADDR_W-1:0] ADDR_BITS  = {REG_OUTPUT_BITS, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_NONE  = {REG_NONE, 2'b00};

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_e;
  typedef enum int {ST_RANDOM, ST_WALK, ST_HOLD, ST_EXTREME} sample_style_e;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic             changed;
  } scaled_out_t;

  // Running boxcar mean and rescale; keeps its own ring and resolution.
  class mean_scaler_model;
    logic [SAMPLE_W-1:0] ring [WIN];
    int unsigned         slot;
    bit                  wrapped;
    logic [OUT_W-1:0]    last_value;
    logic [BITS_W-1:0]   res_bits;
    scaled_out_t         pending_outputs [$];
    int unsigned         samples_in;
    int unsigned         results_seen;
    int unsigned         errors;

    function new();
      slot       = 0;
      wrapped    = 0;
      last_value = '0;
      res_bits   = BITS_RESET;
    endfunction

    function void set_bits(logic [BITS_W-1:0] b);
      res_bits = b;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      int unsigned count;
      int unsigned sum;
      int unsigned mean;
      int unsigned b;
      int unsigned factor;
      int unsigned scaled;
      scaled_out_t o;
      ring[slot] = s;
      slot++;
      if (slot == WIN) begin
        slot    = 0;
        wrapped = 1;
      end
      count = wrapped ? WIN : slot;
      sum = 0;
      for (int i = 0; i < count; i++) sum += ring[i];
      mean = (count != 0) ? sum / count : 0;
      b = (res_bits > BITS_MAX) ? BITS_MAX : res_bits;
      factor = (32'd1 << b) - 1;
      scaled = ((mean * factor) / 4095) & 32'hFFFF;
      o.value   = scaled[OUT_W-1:0];
      o.changed = (o.value != last_value);
      if (o.changed) last_value = o.value;
      pending_outputs.push_back(o);
      samples_in++;
    endfunction

    function void check_result(logic [OUT_W-1:0] value, logic changed);
      scaled_out_t o;
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: scaled_value %0d value_changed %0b", value, changed);
        errors++;
        return;
      end
      o = pending_outputs.pop_front();
      if (value !== o.value) begin
        $error("scaled_value: expected %0d, actual %0d", o.value, value);
        errors++;
      end
      if (changed !== o.changed) begin
        $error("value_changed: expected %0b, actual %0b", o.changed, changed);
        errors++;
      end
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [11:0] sample, [15:12] zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [15:0] scaled_value
  logic                   m_axis_tuser;         // [0] value_changed
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [ADDR_W-1:0]      paddr         = '0;
  logic [DATA_W-1:0]      pwdata        = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  mean_scaler_model model = new();
  int unsigned      cycle_count = 0;
  int unsigned      settings_run = 0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  pot_moving_average_scaler dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               model.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: check each accepted result, stall on a pattern that switches mode.
  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_left  = 0;
  int unsigned rx_hold  = 0;
  logic        rx_level = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      model.check_result(m_axis_tdata, m_axis_tuser);
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_RUNS));
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = $urandom_range(1, 30);
        end else begin
          rx_hold--;
        end
        m_axis_tready <= rx_level;
      end
    endcase
  end

  // Each task is entered at a rising edge and returns at one.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(s);
    do @(posedge clk_i); while (!s_axis_tready);
    model.take_sample(s);
    last_sample = s;
  endtask

  task automatic pause_input(input int unsigned n);
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold the input off until every expected result has come, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_BITS) model.set_bits(data[BITS_W-1:0]);
    @(posedge clk_i);
  endtask

  task automatic check_bits_reg();
    logic [DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BITS;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[BITS_W-1:0] !== model.res_bits) begin
      $error("output_bits: expected %0d, actual %0d", model.res_bits, rd[BITS_W-1:0]);
      model.errors++;
    end
    @(posedge clk_i);
  endtask

  task automatic set_resolution(input logic [BITS_W-1:0] b);
    // junk in the upper data bits must not matter
    reg_write(ADDR_BITS, ($urandom() & ~32'h1F) | DATA_W'(b));
    check_bits_reg();
    settings_run++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(sample_style_e style);
    int v;
    case (style)
      ST_RANDOM: return SAMPLE_W'($urandom_range(0, 4095));
      ST_WALK: begin
        // a slowly turning knob: small steps, often no change in the output
        v = int'(last_sample) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
      end
      ST_HOLD: return last_sample;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 12'h000;
          1:       return 12'hFFF;
          2:       return 12'h800;
          default: return 12'h7FF;
        endcase
      end
    endcase
  endfunction

  task automatic random_phase(input int unsigned items);
    int unsigned   sent;
    int unsigned   burst;
    int unsigned   roll;
    sample_style_e style;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 16);
      roll  = $urandom_range(0, 99);
      style = (roll < 40) ? ST_RANDOM : (roll < 70) ? ST_WALK :
              (roll < 85) ? ST_HOLD : ST_EXTREME;
      for (int i = 0; i < burst && sent < items; i++) begin
        send_sample(pick_sample(style));
        sent++;
      end
      // gaps: none, short, or long; the longest outlast a pass through the divider
      roll = $urandom_range(0, 99);
      if (roll >= 30) pause_input((roll < 80) ? $urandom_range(1, 12) : $urandom_range(13, 45));
    end
  endtask

  initial begin
    logic [BITS_W-1:0] phase_bits [8];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset resolution is twelve bits
    check_bits_reg();

    // partial window, then the wrap; full swings, alternating bit patterns, a repeat
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h123);
    send_sample(12'h123);
    send_sample(12'hFFF);
    drain();

    // widest output: a full window of full scale gives all ones
    set_resolution(5'd16);
    repeat (8) send_sample(12'hFFF);
    drain();

    // zero bits: factor is zero, so the output is stuck at zero
    set_resolution(5'd0);
    send_sample(12'hFFF);
    send_sample(12'h000);
    drain();

    // above sixteen saturates to sixteen
    set_resolution(5'd31);
    send_sample(12'hFFF);
    send_sample(12'h800);
    drain();

    // a write to an address with no register behind it leaves the resolution alone
    reg_write(ADDR_NONE, 32'h0000_0003);
    check_bits_reg();
    send_sample(12'h000);
    send_sample(12'hFFF);
    drain();

    phase_bits = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd12, BITS_W'($urandom_range(2, 15)),
                   BITS_W'($urandom_range(0, 31)), BITS_W'($urandom_range(1, 16))};
    foreach (phase_bits[p]) begin
      set_resolution(phase_bits[p]);
      if ($urandom_range(0, 1)) begin
        reg_write(ADDR_NONE, $urandom());
        check_bits_reg();
      end
      random_phase(PHASE_ITEMS);
      drain();
    end

    $display("summary: %0d samples in, %0d results checked, %0d output resolutions",
             model.samples_in, model.results_seen, settings_run);
    $display("summary: partial and full windows, zero, saturated and out-of-range settings");
    if (model.errors == 0 && model.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
src/pmas_pkg.sv
src/pmas_ram.sv
src/pmas_front.sv
src/pmas_queue.sv
src/pmas_back.sv
src/pot_moving_average_scaler.sv
src/pmas_checker.sv
dv/testbench.sv
